### hw/rtl/cpan_pkg.sv
package cpan_pkg;

    localparam int KEY_W    = 128;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 8;
    localparam int PREFIX_W = 5;
    localparam int ROUND_W  = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd10;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_A  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_A = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_B = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 8'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } cpan_state_t;

    typedef struct packed {
        logic                capture;
        logic                load;
        logic                use_seed;
        logic                round;
        logic                last;
        logic                store_pad;
        logic                store_bit;
        logic                finish;
        logic [PREFIX_W-1:0] prefix;
    } cpan_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 of the AES state sits in the top bits of the word.
    function automatic logic [7:0] get_byte(input logic [KEY_W-1:0] s, input int i);
        return s[KEY_W-1-8*i -: 8];
    endfunction

    function automatic logic [KEY_W-1:0] next_round_key(input logic [KEY_W-1:0] rk,
                                                        input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t  = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [KEY_W-1:0] aes_round(input logic [KEY_W-1:0] s,
                                                   input logic [KEY_W-1:0] rk,
                                                   input logic last);
        logic [7:0] t [16];
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] all;
        logic [KEY_W-1:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int q = 0; q < 4; q++) begin
                t[q + 4*c] = SBOX[get_byte(s, q + 4*((c + q) & 3))];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c+1];
                a2  = t[4*c+2];
                a3  = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[KEY_W-1-8*i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

endpackage

### hw/rtl/cpan_ctrl.sv
module cpan_ctrl #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_hit,
    output cpan_pkg::cpan_cmd_t cmd
);

    localparam logic [cpan_pkg::PREFIX_W-1:0] LAST_PREFIX =
        cpan_pkg::PREFIX_W'(ADDRESS_BITS - 1);

    cpan_pkg::cpan_state_t state_reg, state_next;
    logic [cpan_pkg::ROUND_W-1:0]  round_reg, round_next;
    logic [cpan_pkg::PREFIX_W-1:0] prefix_reg, prefix_next;
    logic pad_mode_reg, pad_mode_next;
    logic pad_ready_reg, pad_ready_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= cpan_pkg::ST_IDLE;
            round_reg     <= '0;
            prefix_reg    <= '0;
            pad_mode_reg  <= 1'b0;
            pad_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            prefix_reg    <= prefix_next;
            pad_mode_reg  <= pad_mode_next;
            pad_ready_reg <= pad_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        prefix_next    = prefix_reg;
        pad_mode_next  = pad_mode_reg;
        pad_ready_next = pad_ready_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.prefix     = prefix_reg;
        cmd.use_seed   = pad_mode_reg;
        in_stall       = 1'b1;
        case (state_reg)
            cpan_pkg::ST_IDLE: begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd.capture   = 1'b1;
                    pad_mode_next = !pad_ready_reg;
                    prefix_next   = '0;
                    state_next    = cpan_pkg::ST_LOAD;
                end
            end
            cpan_pkg::ST_LOAD: begin
                cmd.load   = 1'b1;
                round_next = 4'd1;
                state_next = cpan_pkg::ST_ROUND;
            end
            cpan_pkg::ST_ROUND: begin
                cmd.round  = 1'b1;
                cmd.last   = (round_reg == cpan_pkg::LAST_ROUND);
                round_next = round_reg + 4'd1;
                if (cmd.last) begin
                    if (pad_mode_reg) begin
                        cmd.store_pad  = 1'b1;
                        pad_ready_next = 1'b1;
                        pad_mode_next  = 1'b0;
                        state_next     = cpan_pkg::ST_LOAD;
                    end else begin
                        cmd.store_bit = 1'b1;
                        if (prefix_reg == LAST_PREFIX) begin
                            state_next = cpan_pkg::ST_FINISH;
                        end else begin
                            prefix_next = prefix_reg + 1'b1;
                            state_next  = cpan_pkg::ST_LOAD;
                        end
                    end
                end
            end
            cpan_pkg::ST_FINISH: begin
                if (!out_valid_reg || !out_stall) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cpan_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cpan_pkg::ST_IDLE;
            end
        endcase
        if (cfg_hit) begin
            pad_ready_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/cpan_datapath.sv
module cpan_datapath #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [cpan_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpan_pkg::CFG_W-1:0]         cfg_data,
    input  logic [31:0]                        address,
    input  cpan_pkg::cpan_cmd_t                cmd,
    output logic [31:0]                        anonymized
);

    localparam logic [31:0] ADDR_MASK = 32'hFFFFFFFF >> (32 - ADDRESS_BITS);

    logic [cpan_pkg::CFG_W-1:0] key_a_reg, key_b_reg, seed_a_reg, seed_b_reg;
    logic [cpan_pkg::KEY_W-1:0] state_reg, state_next;
    logic [cpan_pkg::KEY_W-1:0] rk_reg, rk_next;
    logic [cpan_pkg::KEY_W-1:0] pad_reg;
    logic [7:0]                 rcon_reg;
    logic [31:0]                addr_reg;
    logic [31:0]                aligned;
    logic [31:0]                keep;
    logic [31:0]                word;
    logic [cpan_pkg::KEY_W-1:0] block;
    logic [ADDRESS_BITS-1:0]    mask_reg;
    logic [31:0]                result;
    logic [31:0]                anon_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            key_a_reg  <= '0;
            key_b_reg  <= '0;
            seed_a_reg <= '0;
            seed_b_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                cpan_pkg::REG_KEY_A:  key_a_reg  <= cfg_data;
                cpan_pkg::REG_KEY_B:  key_b_reg  <= cfg_data;
                cpan_pkg::REG_SEED_A: seed_a_reg <= cfg_data;
                cpan_pkg::REG_SEED_B: seed_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Prefix block: top p bits from the address, rest from the pad.
    assign aligned = (addr_reg & ADDR_MASK) << (32 - ADDRESS_BITS);
    assign keep    = ~(32'hFFFFFFFF >> cmd.prefix);
    assign word    = (aligned & keep) | (pad_reg[127:96] & ~keep);
    assign block   = cmd.use_seed ? {seed_a_reg, seed_b_reg} : {word, pad_reg[95:0]};

    assign rk_next    = cpan_pkg::next_round_key(rk_reg, rcon_reg);
    assign state_next = cpan_pkg::aes_round(state_reg, rk_next, cmd.last);

    assign result = 32'(mask_reg) ^ (addr_reg & ADDR_MASK);

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            addr_reg <= address;
            mask_reg <= '0;
        end
        if (cmd.load) begin
            state_reg <= block ^ {key_a_reg, key_b_reg};
            rk_reg    <= {key_a_reg, key_b_reg};
            rcon_reg  <= cpan_pkg::RCON_FIRST;
        end
        if (cmd.round) begin
            state_reg <= state_next;
            rk_reg    <= rk_next;
            rcon_reg  <= cpan_pkg::xtime(rcon_reg);
        end
        if (cmd.store_pad) begin
            pad_reg <= state_next;
        end
        if (cmd.store_bit) begin
            mask_reg <= {mask_reg[ADDRESS_BITS-2:0], state_next[127]};
        end
        if (cmd.finish) begin
            anon_reg <= result & ADDR_MASK;
        end
    end

    assign anonymized = anon_reg;

endmodule

### hw/rtl/prefix_preserving_ip_anonymizer_top.sv
// Prefix-preserving IPv4 address anonymizer, AES-128 based.
// Configuration: cfg_write with cfg_index 0..3 loads the key halves and the
// pad seed halves (64 bits each); other indexes are ignored. Any write to
// these marks the pad stale, and it is rederived before the next request.
// Input channel: address with in_valid/in_stall. A request is taken when
// in_valid is high and in_stall low; in_stall stays high while one request
// is in work, so one request is processed at a time.
// Each request runs ADDRESS_BITS AES-128 encryptions, one per prefix
// length, on a single round unit with on-the-fly key expansion; each
// encryption is one load step and ten rounds. The result is registered
// in the finish state after the last encryption, and a new request is
// taken once the block is idle again. The first request after reset or
// configuration runs one extra encryption from the seed to derive the pad.
// Output channel: anonymized with out_valid/out_stall. The result sits in
// an output register, so a new request is taken while it waits; a stalled
// result holds, and a finished request waits until the register is free.
// Reset clears the secret to zero, the control state and output valid.
module prefix_preserving_ip_anonymizer_top #(
    parameter int ADDRESS_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cpan_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cpan_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [31:0]                    anonymized
);

    cpan_pkg::cpan_cmd_t cmd;
    logic cfg_hit;

    // Only writes that land on a real register invalidate the pad.
    assign cfg_hit = cfg_write && (cfg_index < cpan_pkg::REG_COUNT);

    cpan_ctrl #(.ADDRESS_BITS(ADDRESS_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_hit   (cfg_hit),
        .cmd       (cmd)
    );

    cpan_datapath #(.ADDRESS_BITS(ADDRESS_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .address    (address),
        .cmd        (cmd),
        .anonymized (anonymized)
    );

endmodule

### hw/rtl/cpan_checker.sv
module cpan_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] anonymized
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(anonymized))
        else $error("stalled result changed");

    // After a request is taken the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // A fresh result appears only when the block has gone idle again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result appeared while still busy");

endmodule

bind prefix_preserving_ip_anonymizer_top cpan_checker u_cpan_checker (.*);
